FILE: sv/wsbm_pkg.sv
package wsbm_pkg;

  localparam int MAX_BLOCKS_DEF = 16;

  localparam int MIN_W   = 11;  // minute of day, stored and current
  localparam int MASK_W  = 7;
  localparam int ID_W    = 32;
  localparam int SEC_W   = 17;  // result seconds, 0..86400
  localparam int TSEC_W  = 20;  // signed intermediate seconds
  localparam int DMIN_W  = 13;  // signed duration in minutes
  localparam int CFG_W   = 5;

  localparam int MIN_PER_HOUR = 60;
  localparam int SEC_PER_MIN  = 60;
  localparam int MIN_PER_DAY  = 1440;
  localparam int SEC_PER_DAY  = 24 * 60 * 60;

  localparam logic signed [TSEC_W-1:0] SEC_PER_MIN_S = TSEC_W'(SEC_PER_MIN);

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [MIN_W-1:0]  start_min;
    logic [MIN_W-1:0]  end_min;
    logic [MASK_W-1:0] day_mask;
    logic [ID_W-1:0]   block_id;
  } blk_data_t;

  // First hit of a scan
  typedef struct packed {
    logic                     found;
    logic [ID_W-1:0]          block_id;
    logic [MIN_W-1:0]         end_min;
    logic                     wrap;      // matched in the before-midnight part
    logic signed [DMIN_W-1:0] dur_min;
  } hit_rec_t;

  // Weekday 1..7 to bit0..bit6; anything else selects no bit.
  function automatic logic [MASK_W-1:0] day_onehot(input logic [2:0] d);
    logic [MASK_W-1:0] oh;
    oh = '0;
    if (d >= 3'd1 && d <= 3'd7) begin
      oh = MASK_W'(1) << (d - 3'd1);
    end
    return oh;
  endfunction

  function automatic logic [SEC_W-1:0] clamp_day(input logic signed [TSEC_W-1:0] v);
    logic [SEC_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > SEC_PER_DAY) begin
      r = SEC_W'(SEC_PER_DAY);
    end else begin
      r = SEC_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: sv/wsbm_store.sv
module wsbm_store import wsbm_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int IDX_W      = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic             wr_enabled,
  input  blk_data_t        wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic             rd_vld,
  output logic             rd_enabled,
  output blk_data_t        rd_data
);

  blk_data_t              mem_r [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0]  en_flags_r;
  logic                   rd_vld_r;
  logic                   rd_enabled_r;
  blk_data_t              rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r    <= mem_r[rd_addr];
      rd_enabled_r <= en_flags_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_flags_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (wr_en) begin
        en_flags_r[wr_addr] <= wr_enabled;
      end
    end
  end

  assign rd_vld     = rd_vld_r;
  assign rd_enabled = rd_enabled_r;
  assign rd_data    = rd_data_r;

endmodule

FILE: sv/wsbm_match.sv
module wsbm_match import wsbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              rd_vld,
  input  logic              rd_enabled,
  input  blk_data_t         rd_data,
  input  logic [MASK_W-1:0] today_oh,
  input  logic [MASK_W-1:0] yest_oh,
  input  logic [MIN_W-1:0]  now_min,
  output hit_rec_t          rec
);

  hit_rec_t                 rec_r;
  logic                     day_today;
  logic                     day_yest;
  logic                     after_start;
  logic                     before_end;
  logic                     wraps;
  logic                     hit;
  logic                     take;
  logic signed [DMIN_W-1:0] s_s;
  logic signed [DMIN_W-1:0] e_s;
  logic signed [DMIN_W-1:0] dur_min;

  always_comb begin
    day_today   = |(rd_data.day_mask & today_oh);
    day_yest    = |(rd_data.day_mask & yest_oh);
    after_start = now_min >= rd_data.start_min;
    before_end  = now_min <  rd_data.end_min;
    wraps       = rd_data.start_min > rd_data.end_min;
    if (wraps) begin
      hit = (day_today && after_start) || (day_yest && before_end);
    end else begin
      hit = day_today && after_start && before_end;
    end
    s_s = $signed(DMIN_W'(rd_data.start_min));
    e_s = $signed(DMIN_W'(rd_data.end_min));
    // equal start and end counts as a full day
    if (rd_data.end_min <= rd_data.start_min) begin
      dur_min = DMIN_W'(MIN_PER_DAY) - s_s + e_s;
    end else begin
      dur_min = e_s - s_s;
    end
    // first hit only
    take = rd_vld && rd_enabled && hit && !rec_r.found && !clear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.found <= 1'b0;
    end else if (clear) begin
      rec_r.found <= 1'b0;
    end else if (take) begin
      rec_r.found <= 1'b1;
    end
    if (take) begin
      rec_r.block_id <= rd_data.block_id;
      rec_r.end_min  <= rd_data.end_min;
      rec_r.wrap     <= wraps && after_start;
      rec_r.dur_min  <= dur_min;
    end
  end

  assign rec = rec_r;

endmodule

FILE: sv/weekly_schedule_block_match_unit.sv
// Channel  | Direction | Ports                                   | Transfer when
// ---------+-----------+-----------------------------------------+----------------------
// in       | input     | in_valid, in_stall, in_cmd .. in_second | in_valid & !in_stall
// out      | output    | out_valid, out_stall, out_found ..      | out_valid & !out_stall
// cfg      | input     | cfg_we, cfg_wdata                       | cfg_we
//
// A write item does not hold the sequencer; the entry lands in memory at the accepting edge.
// A query reads N = min(entries_in_use, MAX_BLOCKS) entries, one read of the entry
// memory per cycle, then drains the read and compare stages, does the seconds multiply
// and clamps into the output register.
// Reset (rst_n low, synchronous) clears the enable flags, the register and control.
// A finished result waits in the output register; the next item is accepted meanwhile,
// and a query stalls only at its last step while that register is still full.
module weekly_schedule_block_match_unit import wsbm_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [3:0]        in_entry_index,
  input  logic              in_entry_enabled,
  input  logic [MIN_W-1:0]  in_entry_start_minute,
  input  logic [MIN_W-1:0]  in_entry_end_minute,
  input  logic [MASK_W-1:0] in_entry_day_mask,
  input  logic [ID_W-1:0]   in_entry_id,
  input  logic [2:0]        in_day_of_week,
  input  logic [4:0]        in_hour,
  input  logic [5:0]        in_minute,
  input  logic [5:0]        in_second,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [ID_W-1:0]   out_block_id,
  output logic [SEC_W-1:0]  out_seconds_remaining,
  output logic [SEC_W-1:0]  out_duration_seconds
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  entries_in_use_r;
  logic [CNT_W-1:0]  scan_n_r, scan_n_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;

  // query time, held for the whole scan
  logic [MASK_W-1:0] today_oh_r;
  logic [MASK_W-1:0] today_oh_nxt;
  logic [MASK_W-1:0] yest_oh_r;
  logic [MIN_W-1:0]  now_min_r, now_min_nxt;
  logic [5:0]        second_r;
  logic [SEC_W-1:0]  now_sec_r;

  logic signed [TSEC_W-1:0] end_sec_r;
  logic signed [TSEC_W-1:0] dur_sec_r;
  logic signed [TSEC_W-1:0] rem_sec;

  logic              out_valid_r;
  logic              out_found_r;
  logic [ID_W-1:0]   out_block_id_r;
  logic [SEC_W-1:0]  out_rem_r;
  logic [SEC_W-1:0]  out_dur_r;

  logic              in_xfer;
  logic              wr_en;
  logic              query_start;
  logic              rd_en;
  logic              out_free;
  logic              out_load;
  blk_data_t         wr_data;
  logic              rd_vld;
  logic              rd_enabled;
  blk_data_t         rd_data;
  hit_rec_t          rec;

  assign in_stall    = (state_r != ST_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  // slots past the table are dropped
  assign wr_en       = in_xfer && (in_cmd == CMD_WRITE) && (32'(in_entry_index) < MAX_BLOCKS);
  assign query_start = in_xfer && (in_cmd == CMD_QUERY);
  assign rd_en       = (state_r == ST_SCAN) && (ptr_r < scan_n_r);
  assign out_free    = !out_valid_r || !out_stall;
  assign out_load    = (state_r == ST_DONE) && out_free;

  assign wr_data.start_min = in_entry_start_minute;
  assign wr_data.end_min   = in_entry_end_minute;
  assign wr_data.day_mask  = in_entry_day_mask;
  assign wr_data.block_id  = in_entry_id;

  wsbm_store #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_addr    (IDX_W'(in_entry_index)),
    .wr_enabled (in_entry_enabled),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (ptr_r[IDX_W-1:0]),
    .rd_vld     (rd_vld),
    .rd_enabled (rd_enabled),
    .rd_data    (rd_data)
  );

  wsbm_match u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (query_start),
    .rd_vld     (rd_vld),
    .rd_enabled (rd_enabled),
    .rd_data    (rd_data),
    .today_oh   (today_oh_r),
    .yest_oh    (yest_oh_r),
    .now_min    (now_min_r),
    .rec        (rec)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    scan_n_nxt = scan_n_r;
    case (state_r)
      ST_IDLE: begin
        if (query_start) begin
          state_nxt  = ST_SCAN;
          ptr_nxt    = '0;
          scan_n_nxt = (32'(entries_in_use_r) < MAX_BLOCKS) ? CNT_W'(entries_in_use_r)
                                                             : CNT_W'(MAX_BLOCKS);
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end else begin
          // last read is in the compare stage now; record is final next cycle
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      ptr_r            <= '0;
      scan_n_r         <= '0;
      entries_in_use_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      scan_n_r <= scan_n_nxt;
      if (cfg_we) begin
        entries_in_use_r <= cfg_wdata;
      end
    end
  end

  // time of day: minutes captured at accept, seconds registered from them in the cycle after
  assign now_min_nxt  = MIN_W'(in_hour) * MIN_W'(MIN_PER_HOUR) + MIN_W'(in_minute);
  assign today_oh_nxt = day_onehot(in_day_of_week);

  always_ff @(posedge clk) begin
    if (query_start) begin
      today_oh_r <= today_oh_nxt;
      yest_oh_r  <= {today_oh_nxt[0], today_oh_nxt[MASK_W-1:1]};
      now_min_r  <= now_min_nxt;
      second_r   <= in_second;
    end
    now_sec_r <= SEC_W'(now_min_r) * SEC_W'(SEC_PER_MIN) + SEC_W'(second_r);
  end

  // seconds of block end and duration
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      end_sec_r <= $signed(TSEC_W'(rec.end_min) * TSEC_W'(SEC_PER_MIN)
                   + (rec.wrap ? TSEC_W'(SEC_PER_DAY) : TSEC_W'(0)));
      dur_sec_r <= TSEC_W'(rec.dur_min) * SEC_PER_MIN_S;
    end
  end

  assign rem_sec = end_sec_r - $signed(TSEC_W'(now_sec_r));

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= rec.found;
      if (rec.found) begin
        out_block_id_r <= rec.block_id;
        out_rem_r      <= clamp_day(rem_sec);
        out_dur_r      <= clamp_day(dur_sec_r);
      end else begin
        out_block_id_r <= '0;
        out_rem_r      <= '0;
        out_dur_r      <= '0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_found             = out_found_r;
  assign out_block_id          = out_block_id_r;
  assign out_seconds_remaining = out_rem_r;
  assign out_duration_seconds  = out_dur_r;

  // scan pointer never runs past the captured count
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> ptr_r <= scan_n_r)
    else $error("scan pointer past entry count");

  // memory reads only while scanning
  a_rd_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> state_r == ST_SCAN)
    else $error("entry read outside scan");

  // a new result appears only out of the final step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result without finished query");

  // no match gives all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_block_id_r == '0 && out_rem_r == '0
                                    && out_dur_r == '0)
    else $error("nonzero payload on miss");

  // the input side is stalled once a query is accepted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    query_start |=> in_stall)
    else $error("input open during query");

endmodule
